// File: rtl/windowed_average_power_db_assert.svh
// Assertion helpers shared by the RTL modules
`ifndef WINDOWED_AVERAGE_POWER_DB_ASSERT_SVH
`define WINDOWED_AVERAGE_POWER_DB_ASSERT_SVH

// Check that a condition holds on every clock out of reset
`define WAPD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence holds in the same cycle as its trigger
`define WAPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/wapd_pkg.sv
`timescale 1ns / 1ps

package wapd_pkg;

    // Sample format and default window limit
    localparam int unsigned SAMPLE_BITS            = 16;
    localparam int unsigned MAX_WINDOW_SAMPLES_DEF = 1048576;

    // Sample index counter, saturating at all ones
    localparam int unsigned INDEX_W = 24;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    // Configuration registers
    localparam int unsigned US_W       = 16;
    localparam int unsigned RATE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 2'd2;

    localparam logic [US_W-1:0]   WINDOW_START_RST = 16'd0;
    localparam logic [US_W-1:0]   WINDOW_STOP_RST  = 16'hFFFF;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST  = 8'd80;

    // Squared magnitude widths
    localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int unsigned MAG_W = 2 * SAMPLE_BITS;

    // log2 engine: Q1.30 mantissa, 16 fraction bits of log2
    localparam int unsigned MANT_W = 31;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned STEP_W = $clog2(FRAC_W);
    localparam int unsigned NORM_JUMP = 8;

    // dB conversion
    localparam int unsigned K_W = 18;
    localparam logic [K_W-1:0] DB_PER_LOG2_Q16 = 18'd197283;
    localparam int unsigned DB_W      = 16;
    localparam int unsigned DB_FRAC_W = 8;
    localparam int unsigned RND_SHIFT = 2 * FRAC_W - DB_FRAC_W;
    localparam int          DB_FLOOR  = -25600;
    localparam int          DB_CEIL   = 1024;
    localparam int unsigned LOG_OFFSET_Q16 = (2 * (SAMPLE_BITS - 1)) << FRAC_W;

    // Capture queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              not_empty;
        logic [QLVL_W-1:0] level;
    } wapd_q_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORM,
        B_SQUARE,
        B_DIFF,
        B_SCALE,
        B_ROUND,
        B_OUT
    } wapd_back_state_t;

endpackage

// File: rtl/windowed_average_power_db.sv
`timescale 1ns / 1ps
// Mean power of a captured I/Q stream over a time window, in dBFS (Q7.8).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 window start us,
// 1 window stop us (exclusive), 2 sample rate MHz. Always ready; in_ready drops
// for one cycle after each write while the window bounds are recomputed.
// Input channel (in_valid/in_ready): one I/Q sample per request, one per cycle if in_ready.
// last_sample closes the capture; only that request yields a result.
// Output channel (out_valid/out_ready): power_db and status (1 = empty window).
// Each result comes from the shared log2 unit: a normalize search plus 16 squaring
// steps, run for the sum and then for the count, followed by difference, scale and
// round. Zero-power and empty-window results skip straight to the output register.
// Up to two closed captures queue behind the log2 unit; when the queue is full
// in_ready drops. A result waits in the output register while out_ready is low
// and the next capture keeps streaming in.
// Reset clears the sample index, sum and count and restores register defaults
// (start 0, stop 65535, rate 80).
module windowed_average_power_db
    import wapd_pkg::*;
#(
    parameter int unsigned MAX_WINDOW_SAMPLES = MAX_WINDOW_SAMPLES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] q_sample,
    input  logic                          last_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DB_W-1:0]        power_db,
    output logic                          status
);

    localparam int unsigned CNT_W  = $clog2(MAX_WINDOW_SAMPLES + 1);
    localparam int unsigned SUM_W  = MAG_W + CNT_W - 1;
    localparam int unsigned DATA_W = SUM_W + CNT_W;

    wapd_q_status_t    q_status;
    logic              push, pop;
    logic [SUM_W-1:0]  push_sum;
    logic [CNT_W-1:0]  push_cnt;
    logic [DATA_W-1:0] pop_data;

    // Accept, classify and accumulate samples
    wapd_front #(
        .MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES),
        .CNT_W              (CNT_W),
        .SUM_W              (SUM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .i_sample    (i_sample),
        .q_sample    (q_sample),
        .last_sample (last_sample),
        .q_status    (q_status),
        .push        (push),
        .push_sum    (push_sum),
        .push_cnt    (push_cnt)
    );

    // Queue closed captures
    wapd_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_sum, push_cnt}),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Convert each capture to dBFS
    wapd_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop       (pop),
        .pop_sum   (pop_data[DATA_W-1 -: SUM_W]),
        .pop_cnt   (pop_data[CNT_W-1:0]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .power_db  (power_db),
        .status    (status)
    );

endmodule

// File: rtl/wapd_front.sv
`timescale 1ns / 1ps
`include "windowed_average_power_db_assert.svh"

module wapd_front
    import wapd_pkg::*;
#(
    parameter int unsigned MAX_WINDOW_SAMPLES = MAX_WINDOW_SAMPLES_DEF,
    parameter int unsigned CNT_W = $clog2(MAX_WINDOW_SAMPLES + 1),
    parameter int unsigned SUM_W = MAG_W + CNT_W - 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] q_sample,
    input  logic                  last_sample,
    input  wapd_q_status_t        q_status,
    output logic                  push,
    output logic [SUM_W-1:0]      push_sum,
    output logic [CNT_W-1:0]      push_cnt
);

    localparam logic [CNT_W-1:0]   CNT_MAX      = CNT_W'(MAX_WINDOW_SAMPLES);
    localparam logic [INDEX_W-1:0] STOP_IDX_RST =
        INDEX_W'(WINDOW_STOP_RST) * INDEX_W'(SAMPLE_RATE_RST);
    localparam int unsigned ROOM_W = QLVL_W + 1;

    logic [US_W-1:0]    start_us_reg, stop_us_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [INDEX_W-1:0] start_idx_reg, stop_idx_reg;
    logic [INDEX_W-1:0] start_prod, stop_prod;
    logic               settle_reg;

    logic [INDEX_W-1:0] idx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic               a_valid_reg, a_hit_reg, a_last_reg;
    logic [SQ_W-1:0]    a_isq_reg, a_qsq_reg;
    logic [CNT_W-1:0]   a_cnt_reg;

    logic               cfg_write, accept, hit, room;
    logic [CNT_W-1:0]   cnt_inc;
    logic signed [MAG_W-1:0] i_sq_full, q_sq_full;
    logic [MAG_W-1:0]   mag;
    logic [SUM_W-1:0]   sum_total;

    // Take register writes every cycle
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_us_reg <= WINDOW_START_RST;
            stop_us_reg  <= WINDOW_STOP_RST;
            rate_reg     <= SAMPLE_RATE_RST;
            settle_reg   <= 1'b0;
        end
        else
        begin
            settle_reg <= cfg_write;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_WINDOW_START: start_us_reg <= cfg_data;
                    REG_WINDOW_STOP:  stop_us_reg  <= cfg_data;
                    REG_SAMPLE_RATE:  rate_reg     <= cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Convert window bounds from microseconds to sample indices
    assign start_prod = INDEX_W'(start_us_reg) * INDEX_W'(rate_reg);
    assign stop_prod  = INDEX_W'(stop_us_reg) * INDEX_W'(rate_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_idx_reg <= '0;
            stop_idx_reg  <= STOP_IDX_RST;
        end
        else
        begin
            start_idx_reg <= start_prod;
            stop_idx_reg  <= stop_prod;
        end
    end

    // Hold off requests while bounds settle or the queue may overflow
    assign room = (ROOM_W'(q_status.level) + ROOM_W'(a_valid_reg && a_last_reg))
                  < ROOM_W'(QUEUE_DEPTH);
    assign in_ready = !settle_reg && room;
    assign accept   = in_valid && in_ready;

    // Classify the request against the window
    assign hit = (idx_reg != INDEX_MAX) && (idx_reg >= start_idx_reg)
                 && (idx_reg < stop_idx_reg) && (cnt_reg < CNT_MAX);
    assign cnt_inc = cnt_reg + CNT_W'(hit);

    assign i_sq_full = i_sample * i_sample;
    assign q_sq_full = q_sample * q_sample;

    // Advance index and count; clear them after the last sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            cnt_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_hit_reg   <= 1'b0;
            a_last_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            if (accept)
            begin
                a_hit_reg  <= hit;
                a_last_reg <= last_sample;
                if (last_sample)
                begin
                    idx_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    if (idx_reg != INDEX_MAX)
                    begin
                        idx_reg <= idx_reg + INDEX_W'(1);
                    end
                    cnt_reg <= cnt_inc;
                end
            end
        end
    end

    // Capture squares of the accepted sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_isq_reg <= i_sq_full[SQ_W-1:0];
            a_qsq_reg <= q_sq_full[SQ_W-1:0];
            a_cnt_reg <= cnt_inc;
        end
    end

    // Accumulate; hand the capture totals to the queue on the last sample
    assign mag       = MAG_W'(a_isq_reg) + MAG_W'(a_qsq_reg);
    assign sum_total = sum_reg + (a_hit_reg ? SUM_W'(mag) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (a_valid_reg)
        begin
            sum_reg <= a_last_reg ? '0 : sum_total;
        end
    end

    assign push     = a_valid_reg && a_last_reg;
    assign push_sum = sum_total;
    assign push_cnt = a_cnt_reg;

    `WAPD_ASSERT_ALWAYS(a_cnt_limit, clk, rst_n, cnt_reg <= CNT_MAX,
        "summed count passed the window limit")
    `WAPD_ASSERT_IMPLY(a_push_room, clk, rst_n, push,
        q_status.level < QLVL_W'(QUEUE_DEPTH), "capture pushed into a full queue")

endmodule

// File: rtl/wapd_queue.sv
`timescale 1ns / 1ps
`include "windowed_average_power_db_assert.svh"

module wapd_queue
    import wapd_pkg::*;
#(
    parameter int unsigned DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output wapd_q_status_t    status
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;

    // Store the pushed capture
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and track the fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   level_reg <= level_reg + QLVL_W'(1);
                2'b01:   level_reg <= level_reg - QLVL_W'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

    assign pop_data         = entry_reg[rd_ptr_reg];
    assign status.not_empty = (level_reg != '0);
    assign status.level     = level_reg;

    `WAPD_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, pop, level_reg != '0,
        "capture popped from an empty queue")

endmodule

// File: rtl/wapd_back.sv
`timescale 1ns / 1ps
`include "windowed_average_power_db_assert.svh"

module wapd_back
    import wapd_pkg::*;
#(
    parameter int unsigned CNT_W = 21,
    parameter int unsigned SUM_W = MAG_W + CNT_W - 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wapd_q_status_t         q_status,
    output logic                   pop,
    input  logic [SUM_W-1:0]       pop_sum,
    input  logic [CNT_W-1:0]       pop_cnt,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [DB_W-1:0] power_db,
    output logic                   status
);

    localparam int unsigned E_W   = $clog2(SUM_W);
    localparam int unsigned LOG_W = E_W + FRAC_W;
    localparam int unsigned D_W   = LOG_W + 2;
    localparam int unsigned P_W   = D_W + K_W + 1;

    wapd_back_state_t state_reg, state_next;

    logic [SUM_W-1:0]  x_reg, x_next;
    logic [E_W-1:0]    e_reg, e_next;
    logic [MANT_W-1:0] m_reg, m_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              op_cnt_reg, op_cnt_next;
    logic [LOG_W-1:0]  log_sum_reg, log_sum_next;
    logic [CNT_W-1:0]  cnt_hold_reg, cnt_hold_next;
    logic signed [D_W-1:0] d_reg, d_next;
    logic signed [P_W-1:0] prod_reg, prod_next;
    logic [DB_W-1:0]   res_db_reg, res_db_next;
    logic              res_status_reg, res_status_next;

    logic              out_valid_reg;
    logic [DB_W-1:0]   power_db_reg;
    logic              status_reg;
    logic              out_load;

    logic [2*MANT_W-1:0]   sq_full;
    logic [MANT_W:0]       sq_hi;
    logic [P_W-1:0]        prod_abs, rnd_mag;
    logic signed [P_W-1:0] q_val, q_clamped;

    // Square the mantissa for one log2 fraction bit
    assign sq_full = m_reg * m_reg;
    assign sq_hi   = sq_full[2*MANT_W-1 : MANT_W-1];

    // Round the scaled product to Q7.8, half away from zero, and clamp
    always_comb
    begin
        prod_abs = prod_reg[P_W-1] ? P_W'(-prod_reg) : P_W'(prod_reg);
        rnd_mag  = (prod_abs + (P_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
        q_val    = prod_reg[P_W-1] ? $signed(-rnd_mag) : $signed(rnd_mag);
        if (q_val < $signed(P_W'(DB_FLOOR)))
        begin
            q_clamped = $signed(P_W'(DB_FLOOR));
        end
        else if (q_val > $signed(P_W'(DB_CEIL)))
        begin
            q_clamped = $signed(P_W'(DB_CEIL));
        end
        else
        begin
            q_clamped = q_val;
        end
    end

    // Sequence the log2, difference, scale and round steps
    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        e_next          = e_reg;
        m_next          = m_reg;
        frac_next       = frac_reg;
        step_next       = step_reg;
        op_cnt_next     = op_cnt_reg;
        log_sum_next    = log_sum_reg;
        cnt_hold_next   = cnt_hold_reg;
        d_next          = d_reg;
        prod_next       = prod_reg;
        res_db_next     = res_db_reg;
        res_status_next = res_status_reg;
        pop             = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop           = 1'b1;
                    cnt_hold_next = pop_cnt;
                    x_next        = pop_sum;
                    e_next        = E_W'(SUM_W - 1);
                    op_cnt_next   = 1'b0;
                    if (pop_cnt == '0)
                    begin
                        res_db_next     = '0;
                        res_status_next = 1'b1;
                        state_next      = B_OUT;
                    end
                    else if (pop_sum == '0)
                    begin
                        res_db_next     = DB_W'(DB_FLOOR);
                        res_status_next = 1'b0;
                        state_next      = B_OUT;
                    end
                    else
                    begin
                        state_next = B_NORM;
                    end
                end
            end
            B_NORM:
            begin
                if (x_reg[SUM_W-1])
                begin
                    m_next     = x_reg[SUM_W-1 -: MANT_W];
                    frac_next  = '0;
                    step_next  = STEP_W'(FRAC_W - 1);
                    state_next = B_SQUARE;
                end
                else if (x_reg[SUM_W-1 -: NORM_JUMP] == '0)
                begin
                    x_next = x_reg << NORM_JUMP;
                    e_next = e_reg - E_W'(NORM_JUMP);
                end
                else
                begin
                    x_next = x_reg << 1;
                    e_next = e_reg - E_W'(1);
                end
            end
            B_SQUARE:
            begin
                frac_next[step_reg] = sq_hi[MANT_W];
                m_next    = sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    if (!op_cnt_reg)
                    begin
                        log_sum_next = {e_reg, frac_next};
                        x_next       = SUM_W'(cnt_hold_reg);
                        e_next       = E_W'(SUM_W - 1);
                        op_cnt_next  = 1'b1;
                        state_next   = B_NORM;
                    end
                    else
                    begin
                        state_next = B_DIFF;
                    end
                end
            end
            B_DIFF:
            begin
                d_next = $signed(D_W'(log_sum_reg)) - $signed(D_W'({e_reg, frac_reg}))
                         - $signed(D_W'(LOG_OFFSET_Q16));
                state_next = B_SCALE;
            end
            B_SCALE:
            begin
                prod_next  = d_reg * $signed({1'b0, DB_PER_LOG2_Q16});
                state_next = B_ROUND;
            end
            B_ROUND:
            begin
                res_db_next     = q_clamped[DB_W-1:0];
                res_status_next = 1'b0;
                state_next      = B_OUT;
            end
            B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            op_cnt_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_cnt_reg <= op_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        e_reg          <= e_next;
        m_reg          <= m_next;
        frac_reg       <= frac_next;
        step_reg       <= step_next;
        log_sum_reg    <= log_sum_next;
        cnt_hold_reg   <= cnt_hold_next;
        d_reg          <= d_next;
        prod_reg       <= prod_next;
        res_db_reg     <= res_db_next;
        res_status_reg <= res_status_next;
    end

    // Hold the result in the output register until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            power_db_reg <= res_db_reg;
            status_reg   <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign power_db  = $signed(power_db_reg);
    assign status    = status_reg;

    `WAPD_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid_reg && status_reg,
        power_db_reg == '0, "empty-window result with nonzero power")
    `WAPD_ASSERT_IMPLY(a_db_range, clk, rst_n, out_valid_reg && !status_reg,
        ($signed(power_db_reg) >= $signed(DB_W'(DB_FLOOR)))
        && ($signed(power_db_reg) <= $signed(DB_W'(DB_CEIL))),
        "power result outside the dB range")

endmodule

// File: tb/wapd_checker.sv
`timescale 1ns / 1ps

module wapd_checker
    import wapd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] q_sample,
    input  logic                          last_sample,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [DB_W-1:0]        power_db,
    input  logic                          status,
    output int                            mismatch_count,
    output int                            results_pending
);

    typedef struct {
        logic signed [DB_W-1:0] power_db;
        logic                   status;
    } reading_t;

    reading_t expected_readings[$];

    // Shadow registers and capture state
    logic [US_W-1:0]    start_us;
    logic [US_W-1:0]    stop_us;
    logic [RATE_W-1:0]  rate_mhz;
    logic [INDEX_W-1:0] sample_idx;
    logic [63:0]        power_sum;
    logic [31:0]        summed;

    // Scratch for one update
    logic [31:0] win_lo;
    logic [31:0] win_hi;
    logic [63:0] grown;
    longint      ival;
    longint      qval;
    longint      diff;
    longint      scaled;
    longint      rounded;
    reading_t    want;
    int          errors;

    // log2 in Q.16: leading-one position plus 16 squaring steps on a Q1.30 mantissa
    function automatic longint log2_fixed(input logic [63:0] x);
        int          lead;
        int          b;
        logic [63:0] mant;
        longint      frac;
        lead = 63;
        while (lead > 0 && !x[lead])
            lead--;
        mant = (lead >= 30) ? (x >> (lead - 30)) : (x << (30 - lead));
        frac = 0;
        for (b = FRAC_W - 1; b >= 0; b--)
        begin
            mant = (mant * mant) >> 30;
            if (mant >= 64'h8000_0000)
            begin
                frac |= longint'(1) << b;
                mant >>= 1;
            end
        end
        return (longint'(lead) << FRAC_W) + frac;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_us   = WINDOW_START_RST;
            stop_us    = WINDOW_STOP_RST;
            rate_mhz   = SAMPLE_RATE_RST;
            sample_idx = '0;
            power_sum  = '0;
            summed     = '0;
            errors     = 0;
            expected_readings.delete();
            mismatch_count  <= 0;
            results_pending <= 0;
        end
        else
        begin
            // Compare a result leaving the block with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result power_db %0d status %0d",
                                 $realtime, power_db, status);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (power_db !== want.power_db || status !== want.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch power_db exp %0d got %0d, status exp %0d got %0d",
                                     $realtime, want.power_db, power_db, want.status, status);
                    end
                end
            end

            // Advance the capture on an accepted sample request
            if (in_valid && in_ready)
            begin
                win_lo = 32'(start_us) * 32'(rate_mhz);
                win_hi = 32'(stop_us) * 32'(rate_mhz);
                if (sample_idx != INDEX_MAX && 32'(sample_idx) >= win_lo
                    && 32'(sample_idx) < win_hi && summed < MAX_WINDOW_SAMPLES_DEF)
                begin
                    ival      = i_sample;
                    qval      = q_sample;
                    grown     = power_sum + 64'(ival * ival + qval * qval);
                    power_sum = (grown < power_sum) ? '1 : grown;
                    summed++;
                end
                if (sample_idx != INDEX_MAX)
                    sample_idx++;

                // Close the capture and predict its reading
                if (last_sample)
                begin
                    if (summed == 0)
                    begin
                        want.power_db = '0;
                        want.status   = 1'b1;
                    end
                    else if (power_sum == 0)
                    begin
                        want.power_db = DB_W'(DB_FLOOR);
                        want.status   = 1'b0;
                    end
                    else
                    begin
                        diff   = log2_fixed(power_sum) - log2_fixed(64'(summed))
                                 - longint'(LOG_OFFSET_Q16);
                        scaled = diff * longint'(DB_PER_LOG2_Q16);
                        // round half away from zero
                        if (scaled >= 0)
                            rounded = (scaled + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
                        else
                            rounded = -((-scaled + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT);
                        if (rounded < DB_FLOOR)
                            rounded = DB_FLOOR;
                        if (rounded > DB_CEIL)
                            rounded = DB_CEIL;
                        want.power_db = DB_W'(rounded);
                        want.status   = 1'b0;
                    end
                    expected_readings.push_back(want);
                    sample_idx = '0;
                    power_sum  = '0;
                    summed     = '0;
                end
            end

            // Apply register writes after the sample of the same edge
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WINDOW_START: start_us = cfg_data[US_W-1:0];
                    REG_WINDOW_STOP:  stop_us  = cfg_data[US_W-1:0];
                    REG_SAMPLE_RATE:  rate_mhz = cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end

            mismatch_count  <= errors;
            results_pending <= expected_readings.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import wapd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int LONG_ITEMS    = 256;

    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_SMALL, FILL_EXTREME, FILL_SPARSE } fill_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic                          last_sample;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [DB_W-1:0]        power_db;
    logic                          status;
    int                            mismatch_count;
    int                            results_pending;

    int                burst_left;
    bit                steady;
    int                sent_items;
    logic [US_W-1:0]   cur_start;
    logic [US_W-1:0]   cur_stop;
    logic [RATE_W-1:0] cur_rate;
    int                rx_mode = 0;
    int                rx_left = 0;

    always #5 clk = ~clk;

    windowed_average_power_db u_dut (.*);

    wapd_checker u_checker (.*);

    // Stall the result side: always ready, mostly ready, or mostly stalled
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(100, 600);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    initial
    begin
        #60_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input fill_t fill);
        case (fill)
            FILL_ZERO:   return '0;
            FILL_SMALL:  return SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
            FILL_SPARSE: return SAMPLE_BITS'(($urandom_range(0, 15) == 0) ?
                                             ($urandom_range(0, 1) ? 1 : -1) : 0);
            FILL_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return '0;
                    default: return '1;
                endcase
            default:     return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Write one register, then drop the request for a cycle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WINDOW_START: cur_start = data[US_W-1:0];
            REG_WINDOW_STOP:  cur_stop  = data[US_W-1:0];
            REG_SAMPLE_RATE:  cur_rate  = data[RATE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Send one sample request; bursts of random length with random gaps between
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] i_v,
                               input logic signed [SAMPLE_BITS-1:0] q_v,
                               input logic last_v);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid    <= 1'b1;
        i_sample    <= i_v;
        q_sample    <= q_v;
        last_sample <= last_v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        sent_items++;
    endtask

    task automatic send_capture(input int len, input fill_t fill);
        int n;
        for (n = 0; n < len; n++)
            send_sample(pick_sample(fill), pick_sample(fill), n == len - 1);
    endtask

    // Hold off until every reading is back, then let the block drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int    random_start;
        int    hi;
        int    k;
        fill_t fill;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_WINDOW_START;
        cfg_data    = '0;
        in_valid    = 1'b0;
        i_sample    = '0;
        q_sample    = '0;
        last_sample = 1'b0;
        burst_left  = 0;
        steady      = 1'b0;
        sent_items  = 0;
        cur_start   = WINDOW_START_RST;
        cur_stop    = WINDOW_STOP_RST;
        cur_rate    = SAMPLE_RATE_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default window covers every sample: full scale, zero power, floor clamp
        send_sample(16'sh7FFF, 16'sh8000, 1'b1);
        send_sample(16'sh8000, 16'sh8000, 1'b1);
        send_sample('0, '0, 1'b1);
        send_sample(16'sd1, '0, 1'b0);
        send_capture(11, FILL_ZERO);
        settle();

        // Start after stop gives an empty window
        write_reg(REG_WINDOW_START, 16'd3);
        write_reg(REG_WINDOW_STOP, 16'd2);
        write_reg(REG_SAMPLE_RATE, 16'd1);
        send_capture(2, FILL_RANDOM);
        settle();

        // Zero-length window
        write_reg(REG_WINDOW_START, 16'd0);
        write_reg(REG_WINDOW_STOP, 16'd0);
        send_capture(1, FILL_EXTREME);
        settle();

        // Zero rate; upper data bits fall outside the rate register
        write_reg(REG_WINDOW_STOP, 16'd5);
        write_reg(REG_SAMPLE_RATE, 16'hFF00);
        send_capture(1, FILL_RANDOM);
        settle();

        // Top of the start and stop range
        write_reg(REG_WINDOW_START, 16'hFFFF);
        write_reg(REG_WINDOW_STOP, 16'hFFFF);
        write_reg(REG_SAMPLE_RATE, 16'd255);
        send_capture(1, FILL_RANDOM);
        settle();

        // Window lies past the end of the capture
        write_reg(REG_WINDOW_START, 16'd1);
        write_reg(REG_WINDOW_STOP, 16'd2);
        send_capture(3, FILL_RANDOM);
        settle();

        // Capture runs past a two-sample window; the spare index is ignored
        write_reg(REG_WINDOW_START, 16'd0);
        write_reg(REG_WINDOW_STOP, 16'd1);
        write_reg(REG_SAMPLE_RATE, 16'd2);
        write_reg(REG_SPARE, 16'hA5A5);
        send_capture(4, FILL_RANDOM);
        settle();

        // Long capture streamed back to back through a wide window
        write_reg(REG_WINDOW_STOP, 16'hFFFF);
        write_reg(REG_SAMPLE_RATE, 16'd80);
        steady = 1'b1;
        send_capture(LONG_ITEMS, FILL_RANDOM);
        steady = 1'b0;
        settle();

        // Random phases: short windows, a handful of captures each
        random_start = sent_items;
        while (sent_items < random_start + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_WINDOW_START, CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_WINDOW_STOP, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 3) : cur_start + $urandom_range(1, 6)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                          255 : $urandom_range(1, 6)));
            hi = int'(cur_stop) * int'(cur_rate) + 4;
            if (hi > 60)
                hi = 60;
            steady = ($urandom_range(0, 3) == 0);
            for (k = $urandom_range(3, 10); k > 0; k--)
            begin
                fill = ($urandom_range(0, 1) == 0) ? FILL_RANDOM : fill_t'($urandom_range(0, 4));
                send_capture($urandom_range(1, hi), fill);
            end
            settle();
        end

        if (mismatch_count == 0 && results_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/wapd_pkg.sv
rtl/wapd_front.sv
rtl/wapd_queue.sv
rtl/wapd_back.sv
rtl/windowed_average_power_db.sv
tb/wapd_checker.sv
tb/tb.sv
